FILE: hdl/ibse_pkg.sv
// ----------------------------------------------------------------------------
// ibse_pkg
// Types, codes and symbol encoding for the bit-bang symbol encoder.
// ----------------------------------------------------------------------------
package ibse_pkg;

    // command codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RAW   = 2'd3
    } ibse_op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_SCL_PIN = 2'd0;
    localparam logic [1:0] CFG_SDA_PIN = 2'd1;
    localparam logic [1:0] CFG_ENABLE  = 2'd2;

    // register reset values
    localparam logic [2:0] SCL_PIN_RESET = 3'd2;
    localparam logic [2:0] SDA_PIN_RESET = 3'd3;
    localparam logic [7:0] ENABLE_RESET  = 8'hF0;

    // bit period index within a command
    localparam int         IDX_W      = 4;
    localparam logic [IDX_W-1:0] WRITE_LAST = 4'd8;
    localparam logic [IDX_W-1:0] FRAME_LAST = 4'd2;

    // start and stop symbol sequences
    localparam logic [2:0] SYM_START_0 = 3'd7;
    localparam logic [2:0] SYM_START_1 = 3'd6;
    localparam logic [2:0] SYM_START_2 = 3'd4;
    localparam logic [2:0] SYM_STOP_0  = 3'd4;
    localparam logic [2:0] SYM_STOP_1  = 3'd6;
    localparam logic [2:0] SYM_STOP_2  = 3'd7;
    // ack slot releases sda with scl pulsed
    localparam logic [2:0] SYM_ACK     = 3'd1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] payload;
    } ibse_cmd_t;

    typedef struct packed {
        logic [7:0] edge_pins;
        logic [7:0] middle_pins;
        logic       last_of_command;
    } ibse_result_t;

    // pin bytes for one symbol: {edge, middle}
    function automatic logic [15:0] encode_symbol(
        input logic [2:0] sym,
        input logic [2:0] scl_bit,
        input logic [2:0] sda_bit,
        input logic [7:0] enable
    );
        logic [7:0] scl;
        logic [7:0] dlev;
        logic [7:0] held;
        logic [7:0] edge_b;
        logic [7:0] mid_b;
        scl    = 8'd1 << scl_bit;
        dlev   = sym[0] ? (8'd1 << sda_bit) : 8'd0;
        held   = sym[1] ? scl : 8'd0;
        edge_b = dlev | (sym[2] ? held : 8'd0);
        mid_b  = dlev | (sym[2] ? held : scl);
        return {edge_b | enable, mid_b | enable};
    endfunction

endpackage

FILE: hdl/i2c_bitbang_symbol_encoder.sv
// ----------------------------------------------------------------------------
// i2c_bitbang_symbol_encoder
// Expands I2C transmit commands into per-bit-period GPIO pin bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   : one command transfer (opcode, payload) on in_valid/in_ready
//   out channel  : one transfer per I2C bit period on out_valid/out_ready,
//                  carrying edge and middle pin bytes and a last flag
//   cfg channel  : register writes (index, data), always ready; the user must
//                  have them taken only while idle, unchecked by the block
// Throughput: one result per cycle from the output register while out_ready
//   is high; a write byte gives 9 results, start and stop 3, a raw symbol 1.
//   The command register advances its period counter once per result.
// Order: a command transfer loads the command register, and each result
//   then moves to the output register. The next command is taken as the last
//   period of the current one moves to the output register.
// Reset: no command in flight, output empty, registers at scl bit 2,
//   sda bit 3, enable mask 0xF0.
// Stall: when out_ready is low the output register holds its result and
//   the command register holds its place; in_ready drops once a command is
//   waiting.
// ----------------------------------------------------------------------------
module i2c_bitbang_symbol_encoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ibse_pkg::ibse_cmd_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ibse_pkg::ibse_result_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import ibse_pkg::*;

    logic [2:0]       scl_bit_reg;
    logic [2:0]       sda_bit_reg;
    logic [7:0]       enable_reg;

    logic             cmd_valid_reg;
    logic             cmd_valid_next;
    logic [1:0]       op_reg;
    logic [7:0]       pay_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    ibse_result_t     out_reg;

    logic             in_xfer;
    logic             advance;
    logic [2:0]       sym;
    logic             last;
    logic [15:0]      pins;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_bit_reg <= SCL_PIN_RESET;
            sda_bit_reg <= SDA_PIN_RESET;
            enable_reg  <= ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCL_PIN: scl_bit_reg <= cfg_data[2:0];
                CFG_SDA_PIN: sda_bit_reg <= cfg_data[2:0];
                CFG_ENABLE:  enable_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // symbol and last flag for the current bit period
    always_comb
    begin
        sym  = SYM_ACK;
        last = 1'b1;
        case (op_reg)
            OP_WRITE:
            begin
                last = (idx_reg == WRITE_LAST);
                sym  = last ? SYM_ACK : {2'b00, pay_reg[~idx_reg[2:0]]};
            end
            OP_START:
            begin
                last = (idx_reg == FRAME_LAST);
                case (idx_reg[1:0])
                    2'd0:    sym = SYM_START_0;
                    2'd1:    sym = SYM_START_1;
                    default: sym = SYM_START_2;
                endcase
            end
            OP_STOP:
            begin
                last = (idx_reg == FRAME_LAST);
                case (idx_reg[1:0])
                    2'd0:    sym = SYM_STOP_0;
                    2'd1:    sym = SYM_STOP_1;
                    default: sym = SYM_STOP_2;
                endcase
            end
            default:
            begin
                last = 1'b1;
                sym  = pay_reg[2:0];
            end
        endcase
    end

    assign pins = encode_symbol(sym, scl_bit_reg, sda_bit_reg, enable_reg);

    // handshake control
    assign advance  = cmd_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !cmd_valid_reg || (advance && last);
    assign in_xfer  = in_valid && in_ready;

    // command register and period counter
    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        if (in_xfer)
        begin
            cmd_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (advance && last)
        begin
            cmd_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= in_data.opcode;
            pay_reg <= in_data.payload;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.edge_pins       <= pins[15:8];
            out_reg.middle_pins     <= pins[7:0];
            out_reg.last_of_command <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a command transfer restarts the period counter
    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (cmd_valid_reg && idx_reg == '0))
        else $error("command load did not restart period counter");

    // a pending non-final period means the command is still in flight
    a_mid_command: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_of_command) |-> cmd_valid_reg)
        else $error("non-final result with no command in flight");

    // start and stop never run past their third period
    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && (op_reg == OP_START || op_reg == OP_STOP))
            |-> (idx_reg <= FRAME_LAST))
        else $error("start or stop period counter out of range");

    // a write byte never runs past its ack slot
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && op_reg == OP_WRITE) |-> (idx_reg <= WRITE_LAST))
        else $error("write byte period counter out of range");

endmodule

FILE: sim/tb_i2c_bitbang_symbol_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_bitbang_symbol_encoder
// Self-checking bench for the I2C bit-bang symbol encoder. A queue-fed driver
// sends write, start, stop and raw commands, mostly as start/write/stop
// frames with random bytes. A monitor compares every pin result with an
// in-bench expansion of each accepted command. Pin positions and the enable
// mask are reprogrammed between phases, including shared pins and extremes.
// ----------------------------------------------------------------------------
module tb_i2c_bitbang_symbol_encoder;

    import ibse_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_ITEMS  = 45;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned SETTLE_WAIT  = 4;
    localparam int unsigned MAX_REPORTED = 10;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid;
    logic         in_ready;
    ibse_cmd_t    in_data;
    logic         out_valid;
    logic         out_ready;
    ibse_result_t out_data;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [7:0]   cfg_data = '0;

    // bench copy of the registers
    logic [2:0]   pin_scl = SCL_PIN_RESET;
    logic [2:0]   pin_sda = SDA_PIN_RESET;
    logic [7:0]   pin_oe  = ENABLE_RESET;

    ibse_cmd_t    cmd_pending_q[$];
    ibse_result_t pins_expect_q[$];

    bit           idle_on = 1'b0;
    int unsigned  in_gap = 0;
    int unsigned  out_stall = 0;
    int unsigned  n_queued = 0;
    int unsigned  n_accepted = 0;
    int unsigned  n_results = 0;
    int unsigned  n_cfg_writes = 0;
    int unsigned  n_failures = 0;
    int unsigned  cycle_count = 0;

    i2c_bitbang_symbol_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pin bytes for one bit period under the current pin settings
    function automatic ibse_result_t symbol_pins(input logic [2:0] sym, input logic last);
        ibse_result_t r;
        logic [7:0]   scl_m;
        logic [7:0]   sda_lvl;
        logic [7:0]   clk_edge;
        logic [7:0]   clk_mid;
        scl_m   = 8'h01 << pin_scl;
        sda_lvl = sym[0] ? (8'h01 << pin_sda) : 8'h00;
        if (sym[2])
        begin
            // scl held at the level in bit1 for the whole period
            clk_edge = sym[1] ? scl_m : 8'h00;
            clk_mid  = clk_edge;
        end
        else
        begin
            // scl pulsed: low at the edges, high in the middle
            clk_edge = 8'h00;
            clk_mid  = scl_m;
        end
        r.edge_pins       = sda_lvl | clk_edge | pin_oe;
        r.middle_pins     = sda_lvl | clk_mid | pin_oe;
        r.last_of_command = last;
        return r;
    endfunction

    // expected pin results of one accepted command
    task automatic expand_command(input ibse_cmd_t c);
        int i;
        case (ibse_op_t'(c.opcode))
            OP_WRITE:
            begin
                for (i = 7; i >= 0; i--)
                    pins_expect_q.push_back(symbol_pins({2'b00, c.payload[i]}, 1'b0));
                pins_expect_q.push_back(symbol_pins(SYM_ACK, 1'b1));
            end
            OP_START:
            begin
                pins_expect_q.push_back(symbol_pins(SYM_START_0, 1'b0));
                pins_expect_q.push_back(symbol_pins(SYM_START_1, 1'b0));
                pins_expect_q.push_back(symbol_pins(SYM_START_2, 1'b1));
            end
            OP_STOP:
            begin
                pins_expect_q.push_back(symbol_pins(SYM_STOP_0, 1'b0));
                pins_expect_q.push_back(symbol_pins(SYM_STOP_1, 1'b0));
                pins_expect_q.push_back(symbol_pins(SYM_STOP_2, 1'b1));
            end
            default:
                pins_expect_q.push_back(symbol_pins(c.payload[2:0], 1'b1));
        endcase
    endtask

    task automatic note_failure(input string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expand_command(in_data);
                n_accepted++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the offered command until its transfer
            end
            else if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                in_gap = $urandom_range(0, 2);
                in_valid <= 1'b0;
            end
            else if (cmd_pending_q.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= cmd_pending_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        ibse_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pins_expect_q.size() == 0)
                    note_failure($sformatf("unexpected result edge=%02h mid=%02h last=%0b",
                        out_data.edge_pins, out_data.middle_pins, out_data.last_of_command));
                else
                begin
                    want = pins_expect_q.pop_front();
                    if (out_data.edge_pins !== want.edge_pins)
                        note_failure($sformatf("edge_pins expected %02h got %02h",
                            want.edge_pins, out_data.edge_pins));
                    if (out_data.middle_pins !== want.middle_pins)
                        note_failure($sformatf("middle_pins expected %02h got %02h",
                            want.middle_pins, out_data.middle_pins));
                    if (out_data.last_of_command !== want.last_of_command)
                        note_failure($sformatf("last_of_command expected %0b got %0b",
                            want.last_of_command, out_data.last_of_command));
                end
            end
            if (out_stall != 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, pins_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_cmd(input ibse_op_t op, input logic [7:0] pay);
        ibse_cmd_t c;
        c.opcode  = op;
        c.payload = pay;
        cmd_pending_q.push_back(c);
        n_queued++;
    endtask

    // one register transfer; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_SCL_PIN: pin_scl = val[2:0];
            CFG_SDA_PIN: pin_sda = val[2:0];
            CFG_ENABLE:  pin_oe  = val;
            default:     ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic program_pins(input logic [2:0] scl, input logic [2:0] sda,
                                input logic [7:0] oe);
        // junk in the unused upper bits of the pin registers
        write_reg(CFG_SCL_PIN, (8'($urandom) & 8'hF8) | {5'b0, scl});
        write_reg(CFG_SDA_PIN, (8'($urandom) & 8'hF8) | {5'b0, sda});
        write_reg(CFG_ENABLE, oe);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued command has come out as results
    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmd_pending_q.size() != 0 || in_valid || pins_expect_q.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // mostly start/write/stop frames, some broken frames and loose commands
    task automatic queue_random_traffic();
        int unsigned nbytes;
        int unsigned k;
        if ($urandom_range(0, 4) != 0)
        begin
            queue_cmd(OP_START, 8'($urandom));
            nbytes = $urandom_range(1, 4);
            for (k = 0; k < nbytes; k++)
                queue_cmd(OP_WRITE, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
                queue_cmd(OP_RAW, 8'($urandom));
            if ($urandom_range(0, 7) != 0)
                queue_cmd(OP_STOP, 8'($urandom));
        end
        else
            queue_cmd(ibse_op_t'($urandom_range(0, 3)), 8'($urandom));
    endtask

    // stimulus sequence
    initial
    begin
        int unsigned p;
        int unsigned s;
        int unsigned target;
        logic [2:0]  scl;
        logic [2:0]  sda;
        logic [7:0]  oe;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands under reset settings
        idle_on = 1'b1;
        queue_cmd(OP_WRITE, 8'h00);
        queue_cmd(OP_WRITE, 8'hFF);
        queue_cmd(OP_WRITE, 8'h80);
        queue_cmd(OP_WRITE, 8'h01);
        queue_cmd(OP_START, 8'hFF);
        queue_cmd(OP_WRITE, 8'hA5);
        queue_cmd(OP_STOP, 8'hAA);
        // every raw symbol, with the ignored upper payload bits set on odd ones
        for (s = 0; s < 8; s++)
            queue_cmd(OP_RAW, (s % 2 == 1) ? (8'hF8 | 8'(s)) : 8'(s));
        queue_cmd(OP_START, 8'h00);
        queue_cmd(OP_WRITE, 8'h5A);
        queue_cmd(OP_STOP, 8'h55);
        wait_drained();

        // random traffic under a new register setting per phase
        for (p = 1; p <= NUM_PHASES; p++)
        begin
            scl = 3'($urandom);
            sda = 3'($urandom);
            oe  = 8'($urandom);
            case (p)
                1: begin scl = 3'd0; sda = 3'd7; oe = 8'h00; end
                2: begin scl = 3'd7; sda = 3'd0; oe = 8'hFF; end
                3: begin scl = 3'd5; sda = 3'd5; oe = 8'h00; end
                5: sda = scl;
                default: ;
            endcase
            program_pins(scl, sda, oe);
            // no idling on the second phase and in the final stretch
            idle_on = (p != 2 && p != NUM_PHASES);
            target = n_queued + PHASE_ITEMS;
            while (n_queued < target)
                queue_random_traffic();
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (pins_expect_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", pins_expect_q.size()));
        $display("covered %0d commands under %0d register writes, %0d pin results checked",
            n_accepted, n_cfg_writes, n_results);
        $display("settings included shared scl/sda pins and enable masks 00 and FF");
        if (n_failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
